// File: hdl/triangle_unit_normal_unit_macros.svh
// Assertion macros used by the top-level RTL file, triangle_unit_normal_unit.sv.
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TUN_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TUN_ASSERT(label, clk, rst, prop, msg)
`define TUN_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: hdl/tun_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int OUT_BITS = 16;
   localparam int NORM_BITS = 31;
   localparam int Q_ONE = 16384;
   localparam int LEN_BITS = 33;      // isqrt of 3*(2^31)^2 fits 33 bits
   localparam int QUO_BITS = 16;      // quotient capped at 16384, needs 15 bits
endpackage
`default_nettype wire

// File: hdl/triangle_unit_normal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// req_      in   tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z (COORD_BITS each)
// rsp_      out  tdata: normal_x normal_y normal_z degenerate
// One triangle per clock while rsp_ does not stall; the path from the accepting edge to
// rsp_tvalid is 6 front stages, 34 root stages, 17 divider stages, one output register.
// Depth is set by the root and divider pipelines. Reset clears valid bits only.
// A stall on rsp_ freezes the whole pipeline; req_tready is high while the output
// register is empty or being read.
module triangle_unit_normal_unit
   import tun_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0, padded to bytes
   input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // normal_x, normal_y, normal_z, degenerate from bit 0, padded to bytes
   output logic [55:0]                      rsp_tdata
);
   `include "triangle_unit_normal_unit_macros.svh"
   localparam int DB = COORD_BITS + 1;
   localparam int PB = 2*DB;
   localparam int MB = PB + 1;               // magnitude of cross component
   localparam int SIDE = 4 + 3*NORM_BITS;

   logic advance;
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // stage 1: edges
   logic v1_ff;
   logic signed [DB-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   function automatic logic signed [DB-1:0] crd(input logic [((9*COORD_BITS+7)/8)*8-1:0] d,
                                                 input int i);
      crd = DB'($signed(d[i*COORD_BITS +: COORD_BITS]));
   endfunction
   always_ff @(posedge clock) begin
      if (advance) begin
         ux_ff <= crd(req_tdata, 3) - crd(req_tdata, 0);
         uy_ff <= crd(req_tdata, 4) - crd(req_tdata, 1);
         uz_ff <= crd(req_tdata, 5) - crd(req_tdata, 2);
         vx_ff <= crd(req_tdata, 6) - crd(req_tdata, 0);
         vy_ff <= crd(req_tdata, 7) - crd(req_tdata, 1);
         vz_ff <= crd(req_tdata, 8) - crd(req_tdata, 2);
      end
   end

   // stage 2: six products
   logic v2_ff;
   logic signed [PB-1:0] p_ff [6];
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= uy_ff * vz_ff;  p_ff[1] <= uz_ff * vy_ff;
         p_ff[2] <= uz_ff * vx_ff;  p_ff[3] <= ux_ff * vz_ff;
         p_ff[4] <= ux_ff * vy_ff;  p_ff[5] <= uy_ff * vx_ff;
      end
   end

   // stage 3: differences as sign + magnitude
   logic v3_ff;
   logic [2:0] neg_ff;
   logic [MB-1:0] mag_ff [3];
   for (genvar j = 0; j < 3; j++) begin : g_diff
      logic signed [MB:0] d;
      assign d = (MB+1)'(p_ff[2*j]) - (MB+1)'(p_ff[2*j+1]);
      always_ff @(posedge clock) begin
         if (advance) begin
            neg_ff[j] <= d[MB];
            mag_ff[j] <= d[MB] ? MB'(-d) : MB'(d);
         end
      end
   end

   // stage 4: normalize shift below 2^31
   logic v4_ff;
   logic [2:0] neg4_ff;
   logic deg4_ff;
   logic [NORM_BITS-1:0] m_ff [3];
   logic [MB-1:0] orv;
   logic [7:0] top;
   logic [7:0] sh;
   always_comb begin
      orv = mag_ff[0] | mag_ff[1] | mag_ff[2];
      top = '0;
      for (int b = 0; b < MB; b++) begin
         if (orv[b]) top = 8'(b + 1);
      end
      sh = (top > 8'(NORM_BITS)) ? top - 8'(NORM_BITS) : 8'd0;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         neg4_ff <= neg_ff;
         deg4_ff <= (orv == '0);
         for (int j = 0; j < 3; j++) m_ff[j] <= NORM_BITS'(mag_ff[j] >> sh);
      end
   end

   // stage 5: squares then sum
   logic v5_ff;
   logic [65:0] sq_ff;
   logic [2:0] neg5_ff;
   logic deg5_ff;
   logic [NORM_BITS-1:0] m5_ff [3];
   logic [61:0] s0_ff, s1_ff, s2_ff;
   logic v45_ff;
   logic [2:0] neg45_ff;
   logic deg45_ff;
   logic [NORM_BITS-1:0] m45_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= m_ff[0] * m_ff[0];
         s1_ff <= m_ff[1] * m_ff[1];
         s2_ff <= m_ff[2] * m_ff[2];
         neg45_ff <= neg4_ff; deg45_ff <= deg4_ff; m45_ff <= m_ff;
         sq_ff <= 66'(s0_ff) + 66'(s1_ff) + 66'(s2_ff);
         neg5_ff <= neg45_ff; deg5_ff <= deg45_ff; m5_ff <= m45_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v45_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v45_ff <= v4_ff; v5_ff <= v45_ff;
      end
   end

   logic sv;
   logic [32:0] root;
   logic [SIDE-1:0] sside;
   tun_isqrt #(.RAD_BITS(66), .SIDE_BITS(SIDE)) u_isqrt (
      .clock, .reset, .advance, .in_valid(v5_ff), .in_rad(sq_ff),
      .in_side({neg5_ff, deg5_ff, m5_ff[2], m5_ff[1], m5_ff[0]}),
      .out_valid(sv), .out_root(root), .out_side(sside));

   logic [LEN_BITS-1:0] len;
   assign len = (root == '0) ? LEN_BITS'(1) : root;

   logic dv [3];
   logic [QUO_BITS-1:0] q [3];
   logic [3:0] dside [3];
   for (genvar j = 0; j < 3; j++) begin : g_div
      tun_divide #(.SIDE_BITS(4)) u_div (
         .clock, .reset, .advance, .in_valid(sv),
         .in_mag(sside[j*NORM_BITS +: NORM_BITS]), .in_len(len),
         .in_side(sside[SIDE-1 -: 4]),
         .out_valid(dv[j]), .out_quo(q[j]), .out_side(dside[j]));
   end

   logic [55:0] out_ff;
   logic [OUT_BITS-1:0] r [3];
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         r[j] = (q[j] > QUO_BITS'(Q_ONE)) ? OUT_BITS'(Q_ONE) : q[j];
         if (dside[0][0]) r[j] = '0;
         else if (dside[0][j+1]) r[j] = -r[j];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv[0];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) out_ff <= {7'd0, dside[0][0], r[2], r[1], r[0]};
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   `TUN_ASSERT(a_deg_zero, clock, reset,
      !(rsp_tvalid && rsp_tdata[48]) || rsp_tdata[47:0] == '0, "degenerate not zero")
   `TUN_ASSERT(a_lanes, clock, reset, dv[0] == dv[1] && dv[1] == dv[2], "divider lanes skew")
   `TUN_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "output changed under stall")
endmodule
`default_nettype wire

// File: hdl/tun_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root, one result bit per stage; carries a side payload.
module tun_isqrt
   import tun_pkg::*;
#(
   parameter int RAD_BITS = 66,
   parameter int SIDE_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [RAD_BITS-1:0]   in_rad,
   input  wire logic [SIDE_BITS-1:0]  in_side,
   output logic                       out_valid,
   output logic [RAD_BITS/2-1:0]      out_root,
   output logic [SIDE_BITS-1:0]       out_side
);
   localparam int R = RAD_BITS / 2;
   logic [R:0]            valid_ff;
   logic [RAD_BITS-1:0]   rem_ff  [R+1];
   logic [RAD_BITS-1:0]   rad_ff  [R+1];
   logic [R-1:0]          root_ff [R+1];
   logic [SIDE_BITS-1:0]  side_ff [R+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[R-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         rad_ff[0]  <= in_rad;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < R; k++) begin : g_step
      logic [RAD_BITS-1:0] rem_sh;
      logic [RAD_BITS-1:0] trial;
      always_comb begin
         rem_sh = {rem_ff[k][RAD_BITS-3:0], rad_ff[k][RAD_BITS-1 -: 2]};
         trial  = {{(RAD_BITS-R-2){1'b0}}, root_ff[k], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[k+1]  <= {rad_ff[k][RAD_BITS-3:0], 2'b00};
            side_ff[k+1] <= side_ff[k];
            if (rem_sh >= trial) begin
               rem_ff[k+1]  <= rem_sh - trial;
               root_ff[k+1] <= {root_ff[k][R-2:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= rem_sh;
               root_ff[k+1] <= {root_ff[k][R-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[R];
   assign out_root  = root_ff[R];
   assign out_side  = side_ff[R];
endmodule
`default_nettype wire

// File: hdl/tun_divide.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider for round(m*16384/L), one quotient bit per stage.
module tun_divide
   import tun_pkg::*;
#(
   parameter int SIDE_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [NORM_BITS-1:0]  in_mag,
   input  wire logic [LEN_BITS-1:0]   in_len,
   input  wire logic [SIDE_BITS-1:0]  in_side,
   output logic                       out_valid,
   output logic [QUO_BITS-1:0]        out_quo,
   output logic [SIDE_BITS-1:0]       out_side
);
   // numerator 2*m*2^14 + L over 2L; m <= L*sqrt-ish so quotient < 2^16
   localparam int NB = NORM_BITS + 16;
   localparam int DB = LEN_BITS + 1;
   localparam int S  = QUO_BITS;
   logic [S:0]            valid_ff;
   logic [NB+DB-1:0]      rem_ff  [S+1];
   logic [DB-1:0]         den_ff  [S+1];
   logic [S-1:0]          quo_ff  [S+1];
   logic [SIDE_BITS-1:0]  side_ff [S+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[S-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= {{(DB+1){1'b0}}, in_mag, 15'd0} + {{(NB){1'b0}}, 1'b0, in_len};
         den_ff[0]  <= {in_len, 1'b0};
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < S; k++) begin : g_step
      logic [NB+DB-1:0] d_sh;
      assign d_sh = {{NB{1'b0}}, den_ff[k]} << (S-1-k);
      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (rem_ff[k] >= d_sh) begin
               rem_ff[k+1] <= rem_ff[k] - d_sh;
               quo_ff[k+1] <= quo_ff[k] | (S'(1) << (S-1-k));
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               quo_ff[k+1] <= quo_ff[k];
            end
         end
      end
   end

   assign out_valid = valid_ff[S];
   assign out_quo   = quo_ff[S];
   assign out_side  = side_ff[S];
endmodule
`default_nettype wire
